>>> hdl/irmix_pkg.sv
`timescale 1ns / 1ps
// Package for the infrared timing random mixer.
// Holds the mixing constants, field widths and the multiplier request type.
// No dependencies.
package irmix_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned ValueW = 20;
	localparam int unsigned ProdW  = 2 * WordW;

	localparam logic [WordW-1:0] GoldenMix   = 32'h9E37_79B9;
	localparam logic [WordW-1:0] FmixMulA    = 32'h85EB_CA77;
	localparam logic [WordW-1:0] FmixMulB    = 32'hC2B2_AE3D;
	localparam logic [WordW-1:0] DecimalSpan = 32'd1_000_000;
	localparam logic [ValueW-1:0] ValueMax   = 20'd999_999;

	typedef struct packed {
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
	} mul_req_t;

	function automatic logic [WordW-1:0] fold_timing(
		input logic [WordW-1:0] s,
		input logic [WordW-1:0] t
	);
		return s ^ t ^ (s << 5) ^ (s >> 3);
	endfunction

endpackage

>>> hdl/irmix_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the infrared timing random mixer.
// Depends on irmix_pkg for the field widths.
interface irmix_in_if;
	logic                           valid;
	logic                           ready;
	logic [irmix_pkg::WordW-1:0]    pulse_timing;
	logic                           last_timing;
	logic [irmix_pkg::WordW-1:0]    hw_random;

	modport source (output valid, pulse_timing, last_timing, hw_random, input ready);
	modport sink (input valid, pulse_timing, last_timing, hw_random, output ready);
endinterface

interface irmix_out_if;
	logic                           valid;
	logic                           ready;
	logic [irmix_pkg::ValueW-1:0]   random_value;
	logic [irmix_pkg::WordW-1:0]    signal_seed;

	modport source (output valid, random_value, signal_seed, input ready);
	modport sink (input valid, random_value, signal_seed, output ready);
endinterface

>>> hdl/irmix_mul.sv
`timescale 1ns / 1ps
// Shared 32 x 32 multiplier with a registered 64-bit product.
// Depends on irmix_pkg for the request type and widths.
module irmix_mul (
	input  logic                          clk,
	input  irmix_pkg::mul_req_t           req,
	output logic [irmix_pkg::ProdW-1:0]   prod
);

	logic [irmix_pkg::ProdW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= {{irmix_pkg::WordW{1'b0}}, req.a} * {{irmix_pkg::WordW{1'b0}}, req.b};
	end

	assign prod = prod_q;

endmodule

>>> hdl/irmix_seq.sv
`timescale 1ns / 1ps
// Sequencer of the mixer: seed folding, finalizer steps and the result register.
// Depends on irmix_pkg and the channel interfaces; drives the shared multiplier.
module irmix_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	irmix_in_if.sink                      pulses,
	irmix_out_if.source                   results,
	output irmix_pkg::mul_req_t           mul_req,
	input  logic [irmix_pkg::ProdW-1:0]   prod
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_M1   = 4'd1;
	localparam logic [3:0] S_F1   = 4'd2;
	localparam logic [3:0] S_M2   = 4'd3;
	localparam logic [3:0] S_F2   = 4'd4;
	localparam logic [3:0] S_M3   = 4'd5;
	localparam logic [3:0] S_F3   = 4'd6;
	localparam logic [3:0] S_M4   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]                        state_q;
	logic [irmix_pkg::WordW-1:0]       acc_q;
	logic [irmix_pkg::WordW-1:0]       seed_q;
	logic [irmix_pkg::WordW-1:0]       hwr_q;
	logic [irmix_pkg::WordW-1:0]       x_q;
	logic                              out_valid_q;
	logic [irmix_pkg::ValueW-1:0]      value_q;
	logic [irmix_pkg::WordW-1:0]       seed_out_q;
	logic [irmix_pkg::WordW-1:0]       folded;
	logic [irmix_pkg::WordW-1:0]       mix;
	logic                              in_beat;
	logic                              out_free;

	assign in_beat  = pulses.valid && pulses.ready;
	assign out_free = !out_valid_q || results.ready;
	assign folded   = irmix_pkg::fold_timing(acc_q, pulses.pulse_timing);

	assign pulses.ready         = (state_q == S_IDLE);
	assign results.valid        = out_valid_q;
	assign results.random_value = value_q;
	assign results.signal_seed  = seed_out_q;

	always_comb begin
		mul_req.a = x_q;
		case (state_q)
			S_M1: begin
				mul_req.a = seed_q;
				mul_req.b = irmix_pkg::GoldenMix;
			end
			S_M2: mul_req.b = irmix_pkg::FmixMulA;
			S_M3: mul_req.b = irmix_pkg::FmixMulB;
			default: mul_req.b = irmix_pkg::DecimalSpan;
		endcase
	end

	always_comb begin
		if (state_q == S_F1) begin
			mix = hwr_q + prod[irmix_pkg::WordW-1:0];
		end else begin
			mix = prod[irmix_pkg::WordW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					seed_q <= folded;
					hwr_q  <= pulses.hw_random;
				end
			end
			S_F1: x_q <= mix ^ (mix >> 15);
			S_F2: x_q <= mix ^ (mix >> 13);
			S_F3: x_q <= mix ^ (mix >> 16);
			S_DONE: begin
				if (out_free) begin
					value_q    <= prod[irmix_pkg::WordW +: irmix_pkg::ValueW];
					seed_out_q <= seed_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.valid && results.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (pulses.last_timing) begin
							acc_q   <= '0;
							state_q <= S_M1;
						end else begin
							acc_q <= folded;
						end
					end
				end
				S_M1: state_q <= S_F1;
				S_F1: state_q <= S_M2;
				S_M2: state_q <= S_F2;
				S_F2: state_q <= S_M3;
				S_M3: state_q <= S_F3;
				S_F3: state_q <= S_M4;
				S_M4: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_last_starts_mix: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && pulses.last_timing |=> state_q == S_M1 && acc_q == '0)
		else $error("last beat did not start the finalizer with a cleared seed");
	a_plain_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && !pulses.last_timing |=> state_q == S_IDLE)
		else $error("timing beat without last flag left the idle state");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(state_q) == S_DONE)
		else $error("result appeared without a finished mix");
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.random_value <= irmix_pkg::ValueMax)
		else $error("random value above six decimal digits");
`endif

endmodule

>>> hdl/ir_timing_seeded_random_mixer.sv
`timescale 1ns / 1ps
// Top level of the infrared timing random mixer.
// Depends on irmix_pkg, the channel interfaces, irmix_seq and irmix_mul.
//
// Channel   Role    Fields
// pulses    sink    pulse_timing[31:0], last_timing, hw_random[31:0]
// results   source  random_value[19:0], signal_seed[31:0]
//
// A beat without last_timing is folded into the seed register.
// A beat with last_timing then runs the finalizer: four passes through the shared
// 32 x 32 multiplier, three add or shift-xor steps and one high-word capture.
// The result waits in an output register; timing beats are taken meanwhile,
// and a new final beat holds in its last step until the register is free.
// arst_n clears the sequencer, the seed and the result valid flag.
module ir_timing_seeded_random_mixer (
	input  logic          clk,
	input  logic          arst_n,
	irmix_in_if.sink      pulses,
	irmix_out_if.source   results
);

	irmix_pkg::mul_req_t             mul_req;
	logic [irmix_pkg::ProdW-1:0]     prod;

	irmix_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.pulses  (pulses),
		.results (results),
		.mul_req (mul_req),
		.prod    (prod)
	);

	irmix_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for ir_timing_seeded_random_mixer: drives pulse timing beats and checks
// every result against a local seed-fold and hash predictor, with idling on both sides.
// Depends on irmix_pkg, the channel interfaces in irmix_stream_if and the mixer top level.
module testbench;

	typedef struct {
		logic [irmix_pkg::ValueW-1:0] value;
		logic [irmix_pkg::WordW-1:0]  seed;
	} draw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	irmix_in_if  pulses_if ();
	irmix_out_if results_if ();

	ir_timing_seeded_random_mixer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pulses  (pulses_if),
		.results (results_if)
	);

	always #2 clk = ~clk;

	logic [irmix_pkg::WordW-1:0] running_seed = '0;
	draw_t                       expected_draws[$];
	int                          errors = 0;
	bit                          tx_idle_on = 1'b1;
	bit                          rx_idle_on = 1'b1;
	int                          rx_hold_left = 0;
	int                          rx_burst_left = 0;

	function automatic logic [irmix_pkg::WordW-1:0] fold_pulse(
		input logic [irmix_pkg::WordW-1:0] s,
		input logic [irmix_pkg::WordW-1:0] t);
		return s ^ t ^ (s << 5) ^ (s >> 3);
	endfunction

	function automatic logic [irmix_pkg::WordW-1:0] avalanche_word(
		input logic [irmix_pkg::WordW-1:0] w);
		logic [irmix_pkg::WordW-1:0] x;
		x = w;
		x = x ^ (x >> 15);
		x = x * irmix_pkg::FmixMulA;
		x = x ^ (x >> 13);
		x = x * irmix_pkg::FmixMulB;
		x = x ^ (x >> 16);
		return x;
	endfunction

	// Updates the seed for an accepted beat and queues the draw a final beat produces.
	function automatic void predict_pulse(input logic [irmix_pkg::WordW-1:0] t,
		input logic last, input logic [irmix_pkg::WordW-1:0] hwr);
		logic [irmix_pkg::WordW-1:0] seed;
		logic [irmix_pkg::WordW-1:0] mixed;
		logic [irmix_pkg::ProdW-1:0] scaled;
		draw_t                       d;
		seed = fold_pulse(running_seed, t);
		if (!last) begin
			running_seed = seed;
			return;
		end
		mixed = hwr + seed * irmix_pkg::GoldenMix;
		mixed = avalanche_word(mixed);
		scaled = {{irmix_pkg::WordW{1'b0}}, mixed} *
			{{irmix_pkg::WordW{1'b0}}, irmix_pkg::DecimalSpan};
		d.value = scaled[irmix_pkg::WordW +: irmix_pkg::ValueW];
		d.seed = seed;
		expected_draws.push_back(d);
		running_seed = '0;
	endfunction

	function automatic logic [irmix_pkg::WordW-1:0] pick_timing();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: return $urandom_range(150, 20000);
		endcase
	endfunction

	task automatic send_pulse(input logic [irmix_pkg::WordW-1:0] t, input logic last,
		input logic [irmix_pkg::WordW-1:0] hwr);
		int gap;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			repeat (gap) begin
				@(negedge clk);
				pulses_if.valid <= 1'b0;
			end
		end
		@(negedge clk);
		pulses_if.valid <= 1'b1;
		pulses_if.pulse_timing <= t;
		pulses_if.last_timing <= last;
		pulses_if.hw_random <= hwr;
		do @(posedge clk); while (!pulses_if.ready);
		predict_pulse(t, last, hwr);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		pulses_if.valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
	endtask

	task automatic run_signals(input int n_items, input int max_len);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, max_len);
			for (int i = 0; i < len; i++) begin
				send_pulse(pick_timing(), i == len - 1, $urandom());
			end
			sent += len;
		end
	endtask

	task automatic test_directed();
		send_pulse(32'h0000_0000, 1'b1, 32'h0000_0000);
		send_pulse(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_pulse(32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
		send_pulse(32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
		send_pulse(32'hFFFF_FFFF, 1'b0, 32'hAAAA_AAAA);
		send_pulse(32'hFFFF_FFFF, 1'b0, 32'h5555_5555);
		send_pulse(32'hFFFF_FFFF, 1'b1, 32'h1234_5678);
		send_pulse(32'h5555_5555, 1'b0, 32'hFFFF_FFFF);
		send_pulse(32'hAAAA_AAAA, 1'b0, 32'h0000_0000);
		send_pulse(32'd9000, 1'b1, 32'hAAAA_AAAA);
		send_pulse(32'd9000, 1'b0, 32'h0000_0000);
		send_pulse(32'd4500, 1'b0, 32'h0000_0000);
		send_pulse(32'd560, 1'b0, 32'h0000_0000);
		send_pulse(32'd1690, 1'b1, 32'h5555_5555);
		send_pulse(32'h0000_0000, 1'b0, 32'h0000_0000);
		send_pulse(32'h0000_0000, 1'b1, 32'h8000_0000);
		wait_drained();
	endtask

	task automatic test_random_signals();
		for (int seg = 0; seg < 4; seg++) begin
			tx_idle_on = (seg != 2);
			rx_idle_on = (seg != 1);
			run_signals(250, (seg == 3) ? 40 : 8);
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		@(posedge clk);
		rx_hold_left = 300;
		run_signals(60, 3);
		wait_drained();
		tx_idle_on = 1'b1;
	endtask

	task automatic test_no_idle();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_signals(300, 6);
		wait_drained();
	endtask

	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				results_if.ready <= 1'b0;
				rx_hold_left--;
			end else if (rx_burst_left > 0) begin
				results_if.ready <= 1'b0;
				rx_burst_left--;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				results_if.ready <= 1'b0;
				rx_burst_left = $urandom_range(1, 14) - 1;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		draw_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_draws.size() == 0) begin
				$error("unexpected result: random_value %0d signal_seed %h",
					results_if.random_value, results_if.signal_seed);
				errors++;
			end else begin
				want = expected_draws.pop_front();
				if (results_if.random_value !== want.value) begin
					$error("random_value: expected %0d, actual %0d", want.value,
						results_if.random_value);
					errors++;
				end
				if (results_if.signal_seed !== want.seed) begin
					$error("signal_seed: expected %h, actual %h", want.seed,
						results_if.signal_seed);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		pulses_if.valid = 1'b0;
		pulses_if.pulse_timing = '0;
		pulses_if.last_timing = 1'b0;
		pulses_if.hw_random = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_signals();
		test_backpressure();
		test_no_idle();
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

>>> files.f
hdl/irmix_pkg.sv
hdl/irmix_stream_if.sv
hdl/irmix_mul.sv
hdl/irmix_seq.sv
hdl/ir_timing_seeded_random_mixer.sv
verif/testbench.sv
